>>> rtl/core/ssr_pkg.sv
// shared types and constants of the servo slew-rate ramp
// no dependencies; imported by every module of the block
package ssr_pkg;

   localparam int unsigned ANGLE_W = 8;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned MODE_W  = 3;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [ANGLE_W-1:0] MAX_ANGLE     = 8'd180;
   localparam logic [ANGLE_W-1:0] MIN_DEG_RESET = 8'd0;
   localparam logic [ANGLE_W-1:0] MAX_DEG_RESET = 8'd180;

   typedef enum logic [MODE_W-1:0] {
      MODE_MOVE   = 3'd0,
      MODE_CLEAR  = 3'd1,
      MODE_LOCK   = 3'd2,
      MODE_UNLOCK = 3'd3,
      MODE_TOGGLE = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_DEG = 1'd0,
      CSR_MAX_DEG = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic               start_cond;
      logic               auto_cond;
      logic [ANGLE_W-1:0] target_deg;
      logic [ANGLE_W-1:0] step_ms;
      logic [TIME_W-1:0]  now_ms;
   } req_item_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] position_deg;
      logic               is_done;
      logic               is_moving;
      logic               is_locked;
      logic [ANGLE_W-1:0] move_id;
   } rsp_item_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] min_deg;
      logic [ANGLE_W-1:0] max_deg;
   } cfg_type;

endpackage

>>> rtl/core/ssr_in_stage.sv
// input register of the servo slew-rate ramp
// holds one accepted item until the update logic takes it; uses ssr_pkg
module ssr_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 take,
   input  ssr_pkg::req_item_type item,
   output logic                 held_valid,
   output ssr_pkg::req_item_type held_item
);
   import ssr_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign valid_in = load | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;
endmodule

>>> rtl/core/ssr_engine.sv
// servo state registers and the single-pass update for one item
// clamp, start check, jump or timed one-degree step; uses ssr_pkg
module ssr_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ssr_pkg::req_item_type item,
   input  ssr_pkg::cfg_type      cfg,
   output ssr_pkg::rsp_item_type result
);
   import ssr_pkg::*;

   logic [ANGLE_W-1:0] pos_ff, pos_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic [ANGLE_W-1:0] count_ff, count_in;
   logic               moving_ff, moving_in;
   logic               done_ff, done_in;
   logic               lock_ff, lock_in;

   logic               cond;
   logic [ANGLE_W-1:0] tgt_lo;
   logic [ANGLE_W-1:0] tgt;
   logic [ANGLE_W-1:0] pos_jump;
   logic [ANGLE_W:0]   pos_inc;
   logic [ANGLE_W-1:0] pos_up;
   logic [TIME_W-1:0]  elapsed;
   logic               hit;

   assign cond    = item.auto_cond ? (count_ff == '0) : item.start_cond;
   assign tgt_lo  = (item.target_deg < cfg.min_deg) ? cfg.min_deg : item.target_deg;
   assign tgt     = (tgt_lo > cfg.max_deg) ? cfg.max_deg : tgt_lo;
   assign pos_jump = (item.step_ms == '0) ? ((tgt > MAX_ANGLE) ? MAX_ANGLE : tgt) : pos_ff;
   assign hit     = (tgt == pos_jump);
   assign pos_inc = {1'b0, pos_jump} + {{ANGLE_W{1'b0}}, 1'b1};
   assign pos_up  = (pos_inc > {1'b0, MAX_ANGLE}) ? MAX_ANGLE : pos_inc[ANGLE_W-1:0];
   assign elapsed = item.now_ms - last_ff;

   always_comb begin
      pos_in    = pos_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      moving_in = moving_ff;
      done_in   = done_ff;
      lock_in   = lock_ff;
      case (item.mode)
         MODE_MOVE: begin
            if (cond && !lock_ff) begin
               pos_in  = pos_jump;
               done_in = 1'b0;
               if (hit) begin
                  done_in   = 1'b1;
                  moving_in = 1'b0;
                  count_in  = count_ff + 8'd1;
               end else if (!moving_ff) begin
                  last_in   = item.now_ms;
                  moving_in = 1'b1;
               end else if (elapsed >= {{(TIME_W-ANGLE_W){1'b0}}, item.step_ms}) begin
                  last_in = item.now_ms;
                  if (tgt > pos_jump) begin
                     pos_in = pos_up;
                  end else if (pos_jump != '0) begin
                     pos_in = pos_jump - 8'd1;
                  end
               end
            end
         end
         MODE_CLEAR: begin
            count_in  = '0;
            moving_in = 1'b0;
            done_in   = 1'b0;
         end
         MODE_LOCK:   lock_in = 1'b1;
         MODE_UNLOCK: lock_in = 1'b0;
         MODE_TOGGLE: lock_in = ~lock_ff;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         last_ff   <= '0;
         count_ff  <= '0;
         moving_ff <= 1'b0;
         done_ff   <= 1'b0;
         lock_ff   <= 1'b0;
      end else if (fire) begin
         pos_ff    <= pos_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
         moving_ff <= moving_in;
         done_ff   <= done_in;
         lock_ff   <= lock_in;
      end
   end

   assign result.position_deg = pos_in;
   assign result.is_done      = done_in;
   assign result.is_moving    = moving_in;
   assign result.is_locked    = lock_in;
   assign result.move_id      = count_in;
endmodule

>>> rtl/core/servo_slew_rate_ramp.sv
// Servo slew-rate ramp, top level.
// Each item on the req_ channel is one control update: a move request or a
// change of the id, flags or lock. Each item gives exactly one item on the
// rsp_ channel with the servo state after that update.
// Both channels use valid and stall; an item moves at a clock edge with
// valid high and stall low.
// An accepted item waits in the input register; its result is then shown
// from the result register. Throughput: one item per cycle, sustained while
// rsp_stall is low; the state update is one pass of clamp, compare, 32-bit
// subtract and increment between the input register and the result register.
// When rsp_stall holds a result, the input register still takes one more
// item; req_stall rises only once that register is also full.
// Configuration: csr_wr_en writes min_deg (index 0) or max_deg (index 1);
// write only while no item is in flight.
// Reset (synchronous, active high) clears position, timestamp, id and
// flags, sets min_deg to 0 and max_deg to 180, and empties both registers.
// Depends on ssr_pkg, ssr_in_stage and ssr_engine.
module servo_slew_rate_ramp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ssr_pkg::MODE_W-1:0]      req_mode,
   input  logic                            req_start_cond,
   input  logic                            req_auto_cond,
   input  logic [ssr_pkg::ANGLE_W-1:0]     req_target_deg,
   input  logic [ssr_pkg::ANGLE_W-1:0]     req_step_ms,
   input  logic [ssr_pkg::TIME_W-1:0]      req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ssr_pkg::ANGLE_W-1:0]     rsp_position_deg,
   output logic                            rsp_is_done,
   output logic                            rsp_is_moving,
   output logic                            rsp_is_locked,
   output logic [ssr_pkg::ANGLE_W-1:0]     rsp_move_id,
   input  logic                            csr_wr_en,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ssr_pkg::*;

   req_item_type req_item;
   req_item_type held_item;
   logic         held_valid;
   logic         advance;
   logic         fire;
   logic         load;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   cfg_type      cfg_ff;

   assign req_item.mode       = req_mode;
   assign req_item.start_cond = req_start_cond;
   assign req_item.auto_cond  = req_auto_cond;
   assign req_item.target_deg = req_target_deg;
   assign req_item.step_ms    = req_step_ms;
   assign req_item.now_ms     = req_now_ms;

   // result register free or being emptied this cycle
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign fire      = held_valid & advance;
   assign req_stall = held_valid & ~advance;
   assign load      = req_valid & ~req_stall;

   ssr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .take       (fire),
      .item       (req_item),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   ssr_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (held_item),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_deg <= MIN_DEG_RESET;
         cfg_ff.max_deg <= MAX_DEG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_DEG: cfg_ff.min_deg <= csr_wdata[ANGLE_W-1:0];
            CSR_MAX_DEG: cfg_ff.max_deg <= csr_wdata[ANGLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position_deg = rsp_ff.position_deg;
   assign rsp_is_done      = rsp_ff.is_done;
   assign rsp_is_moving    = rsp_ff.is_moving;
   assign rsp_is_locked    = rsp_ff.is_locked;
   assign rsp_move_id      = rsp_ff.move_id;
endmodule
